// ===== rtl/cpa_pkg.sv =====
// ----------------------------------------------------------------------------
// cpa_pkg
// Shared types, field widths and codes for the contiguous page allocator.
// ----------------------------------------------------------------------------
package cpa_pkg;

    localparam int OPCODE_W   = 2;
    localparam int COUNT_W    = 9;
    localparam int START_W    = 8;
    localparam int STATUS_W   = 2;
    localparam int BASE_W     = 24;
    localparam int PAGE_NUM_W = 25;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;

    // page positions up to start + count (255 + 511)
    localparam int POS_W      = 10;

    // the free map is held as 32-bit words, scanned 8 pages a cycle
    localparam int WORD_W     = 32;
    localparam int WORD_SH    = 5;
    localparam int CHUNK_W    = 8;
    localparam int CHUNK_SH   = 3;

    // pages_in_use cannot address past this, whatever the map depth
    localparam int MAP_CAP    = 1 << COUNT_W;

    localparam logic [OPCODE_W-1:0] OP_ALLOC_TASK  = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_ALLOC_SUPER = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_RELEASE     = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NORUN = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BAD   = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_BASE_PAGE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PAGES_IN_USE = 2'd1;

    typedef enum logic [1:0] {
        CMD_ALLOC_LO,
        CMD_ALLOC_HI,
        CMD_RELEASE,
        CMD_REJECT
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t            kind;
        logic [COUNT_W-1:0]   count;
        logic [START_W-1:0]   start;
    } cmd_t;

endpackage

// ===== rtl/cpa_front.sv =====
// ----------------------------------------------------------------------------
// cpa_front
// Takes requests, checks count and range against the page limit and turns
// each into a command for the back end.
// ----------------------------------------------------------------------------
module cpa_front
    import cpa_pkg::*;
(
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [OPCODE_W-1:0]  s_opcode,
    input  logic [COUNT_W-1:0]   s_page_count,
    input  logic [START_W-1:0]   s_start_page,
    input  logic [COUNT_W-1:0]   limit,
    output logic                 q_valid,
    input  logic                 q_ready,
    output cmd_t                 q_cmd
);

    logic [POS_W-1:0] range_end;

    assign range_end = POS_W'(s_start_page) + POS_W'(s_page_count);

    assign s_ready = q_ready;
    assign q_valid = s_valid;

    always_comb begin
        q_cmd.count = s_page_count;
        q_cmd.start = s_start_page;
        unique case (s_opcode) inside
            OP_ALLOC_TASK, OP_ALLOC_SUPER: begin
                if (s_page_count == '0 || s_page_count > limit) begin
                    q_cmd.kind = CMD_REJECT;
                end else if (s_opcode == OP_ALLOC_TASK) begin
                    q_cmd.kind = CMD_ALLOC_LO;
                end else begin
                    q_cmd.kind = CMD_ALLOC_HI;
                end
            end
            OP_RELEASE: begin
                if (s_page_count == '0 || range_end > POS_W'(limit)) begin
                    q_cmd.kind = CMD_REJECT;
                end else begin
                    q_cmd.kind = CMD_RELEASE;
                end
            end
            default: begin
                q_cmd.kind = CMD_REJECT;
            end
        endcase
    end

endmodule

// ===== rtl/cpa_queue.sv =====
// ----------------------------------------------------------------------------
// cpa_queue
// Small first-in first-out command queue between front and back end.
// ----------------------------------------------------------------------------
module cpa_queue #(
    parameter int WIDTH = 21,
    parameter int DEPTH = 2
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [WIDTH-1:0] in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [WIDTH-1:0] out_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] fill_reg, fill_next;
    logic             push, pop;

    assign in_ready  = (fill_reg != CNT_W'(DEPTH));
    assign out_valid = (fill_reg != '0);
    assign out_data  = mem_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            fill_next = fill_reg + 1'b1;
        end else if (pop && !push) begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= in_data;
        end
    end

endmodule

// ===== rtl/cpa_back.sv =====
// ----------------------------------------------------------------------------
// cpa_back
// Holds the free map and carries out commands: run search eight pages a cycle
// (allocates), word-by-word map update (found runs, releases), result register.
// ----------------------------------------------------------------------------
module cpa_back
    import cpa_pkg::*;
#(
    parameter int NUM_PAGES = 256
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  q_valid,
    output logic                  q_ready,
    input  cmd_t                  q_cmd,
    input  logic [COUNT_W-1:0]    limit,
    input  logic [BASE_W-1:0]     base_page,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [STATUS_W-1:0]   m_status,
    output logic [PAGE_NUM_W-1:0] m_page_number
);

    // only the pages that pages_in_use can reach are stored
    localparam int MAP_PAGES = (NUM_PAGES < MAP_CAP) ? NUM_PAGES : MAP_CAP;
    localparam int WORDS     = (MAP_PAGES + WORD_W - 1) / WORD_W;
    localparam int WIDX_W    = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int CI_W      = WIDX_W + (WORD_SH - CHUNK_SH);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_WRITE,
        S_EMIT
    } state_t;

    state_t                  state_reg, state_next;
    cmd_kind_t               kind_reg, kind_next;
    logic [COUNT_W-1:0]      count_reg, count_next;
    logic [POS_W-1:0]        run_reg, run_next;
    logic [CI_W-1:0]         chunk_reg, chunk_next;
    logic [POS_W-1:0]        lo_reg, lo_next;
    logic [POS_W-1:0]        hi_reg, hi_next;
    logic [WIDX_W-1:0]       word_reg, word_next;
    logic [STATUS_W-1:0]     res_status_reg, res_status_next;
    logic [POS_W-1:0]        res_start_reg, res_start_next;
    logic                    m_valid_reg, m_valid_next;
    logic [STATUS_W-1:0]     m_status_reg, m_status_next;
    logic [PAGE_NUM_W-1:0]   m_page_number_reg, m_page_number_next;

    logic [WORD_W-1:0]       map_reg [WORDS];
    logic [WORD_W-1:0]       map_word_next;
    logic                    map_we;

    logic                    desc;
    logic [POS_W-1:0]        lim_ext;
    logic [CI_W-1:0]         last_chunk;
    logic [WORD_W-1:0]       scan_word;
    logic [CHUNK_W-1:0]      chunk_bits;
    logic [POS_W-1:0]        scan_run;
    logic                    hit;
    logic [POS_W-1:0]        hit_pos;
    logic [POS_W-1:0]        hit_start;
    logic [POS_W-1:0]        hit_end;
    logic [WORD_W-1:0]       upd_mask;
    logic [WORD_W-1:0]       upd_word;
    logic [POS_W-1:0]        rel_start;
    logic [POS_W-1:0]        rel_end;
    logic [POS_W-1:0]        last_minus;

    assign desc       = (kind_reg == CMD_ALLOC_HI);
    assign lim_ext    = POS_W'(limit);
    assign last_minus = (lim_ext - 1'b1) >> CHUNK_SH;
    assign last_chunk = last_minus[CI_W-1:0];
    assign scan_word  = map_reg[chunk_reg[CI_W-1:WORD_SH-CHUNK_SH]];
    assign chunk_bits = scan_word[{chunk_reg[WORD_SH-CHUNK_SH-1:0], 3'b000} +: CHUNK_W];

    // eight pages per cycle, in the direction of the search
    always_comb begin
        scan_run = run_reg;
        hit      = 1'b0;
        hit_pos  = '0;
        for (int k = 0; k < CHUNK_W; k++) begin
            int               b;
            logic [POS_W-1:0] pg;
            logic             fr;
            b  = desc ? (CHUNK_W - 1 - k) : k;
            pg = POS_W'({chunk_reg, 3'(b)});
            fr = chunk_bits[b] && (pg < lim_ext);
            scan_run = fr ? scan_run + 1'b1 : '0;
            if (!hit && scan_run == POS_W'(count_reg)) begin
                hit     = 1'b1;
                hit_pos = pg;
            end
        end
    end

    assign hit_start = desc ? hit_pos : hit_pos + 1'b1 - POS_W'(count_reg);
    assign hit_end   = desc ? hit_pos + POS_W'(count_reg) - 1'b1 : hit_pos;
    assign rel_start = POS_W'(q_cmd.start);
    assign rel_end   = rel_start + POS_W'(q_cmd.count) - 1'b1;

    always_comb begin
        for (int b = 0; b < WORD_W; b++) begin
            logic [POS_W-1:0] pg;
            pg = POS_W'({word_reg, 5'(b)});
            upd_mask[b] = (pg >= lo_reg) && (pg <= hi_reg);
        end
        upd_word = map_reg[word_reg];
    end

    always_comb begin
        state_next         = state_reg;
        kind_next          = kind_reg;
        count_next         = count_reg;
        run_next           = run_reg;
        chunk_next         = chunk_reg;
        lo_next            = lo_reg;
        hi_next            = hi_reg;
        word_next          = word_reg;
        res_status_next    = res_status_reg;
        res_start_next     = res_start_reg;
        m_valid_next       = m_valid_reg && !m_ready;
        m_status_next      = m_status_reg;
        m_page_number_next = m_page_number_reg;
        map_we             = 1'b0;
        map_word_next      = (kind_reg == CMD_RELEASE) ? (upd_word | upd_mask)
                                                       : (upd_word & ~upd_mask);
        unique case (state_reg)
            S_IDLE: begin
                if (q_valid) begin
                    kind_next  = q_cmd.kind;
                    count_next = q_cmd.count;
                    run_next   = '0;
                    case (q_cmd.kind)
                        CMD_ALLOC_LO: begin
                            chunk_next = '0;
                            state_next = S_SCAN;
                        end
                        CMD_ALLOC_HI: begin
                            chunk_next = last_chunk;
                            state_next = S_SCAN;
                        end
                        CMD_RELEASE: begin
                            lo_next         = rel_start;
                            hi_next         = rel_end;
                            word_next       = rel_start[WIDX_W+WORD_SH-1:WORD_SH];
                            res_start_next  = rel_start;
                            res_status_next = ST_OK;
                            state_next      = S_WRITE;
                        end
                        default: begin
                            res_status_next = ST_BAD;
                            state_next      = S_EMIT;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                run_next = scan_run;
                if (hit) begin
                    lo_next         = hit_start;
                    hi_next         = hit_end;
                    word_next       = hit_start[WIDX_W+WORD_SH-1:WORD_SH];
                    res_start_next  = hit_start;
                    res_status_next = ST_OK;
                    state_next      = S_WRITE;
                end else if ((!desc && chunk_reg == last_chunk) ||
                             (desc && chunk_reg == '0)) begin
                    res_status_next = ST_NORUN;
                    state_next      = S_EMIT;
                end else if (desc) begin
                    chunk_next = chunk_reg - 1'b1;
                end else begin
                    chunk_next = chunk_reg + 1'b1;
                end
            end
            S_WRITE: begin
                map_we = 1'b1;
                if (word_reg == hi_reg[WIDX_W+WORD_SH-1:WORD_SH]) begin
                    state_next = S_EMIT;
                end else begin
                    word_next = word_reg + 1'b1;
                end
            end
            S_EMIT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next       = 1'b1;
                    m_status_next      = res_status_reg;
                    m_page_number_next = (res_status_reg == ST_OK)
                                       ? PAGE_NUM_W'(base_page) + PAGE_NUM_W'(res_start_reg)
                                       : '0;
                    state_next         = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= S_IDLE;
            m_valid_reg       <= 1'b0;
            m_status_reg      <= ST_OK;
            m_page_number_reg <= '0;
        end else begin
            state_reg         <= state_next;
            m_valid_reg       <= m_valid_next;
            m_status_reg      <= m_status_next;
            m_page_number_reg <= m_page_number_next;
        end
        kind_reg       <= kind_next;
        count_reg      <= count_next;
        run_reg        <= run_next;
        chunk_reg      <= chunk_next;
        lo_reg         <= lo_next;
        hi_reg         <= hi_next;
        word_reg       <= word_next;
        res_status_reg <= res_status_next;
        res_start_reg  <= res_start_next;
    end

    // free map: cleared at reset, no page free
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int w = 0; w < WORDS; w++) begin
                map_reg[w] <= '0;
            end
        end else if (map_we) begin
            map_reg[word_reg] <= map_word_next;
        end
    end

    assign q_ready       = (state_reg == S_IDLE);
    assign m_valid       = m_valid_reg;
    assign m_status      = m_status_reg;
    assign m_page_number = m_page_number_reg;

    a_fail_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_status_reg != ST_OK) |-> (m_page_number_reg == '0))
        else $error("failed request carries a page number");

    a_write_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_WRITE) |-> (lo_reg <= hi_reg && hi_reg < lim_ext))
        else $error("map update range outside the managed pages");

    a_scan_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_SCAN) |-> (chunk_reg <= last_chunk && count_reg <= limit))
        else $error("search ran past the page limit");

    a_take_cmd: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_IDLE && q_valid) |=> (state_reg != S_IDLE))
        else $error("queued command not taken");

endmodule

// ===== rtl/contiguous_page_allocator.sv =====
// ----------------------------------------------------------------------------
// contiguous_page_allocator
// First-fit allocator of contiguous page runs over a one-bit-per-page map.
// ----------------------------------------------------------------------------
// Requests are checked on entry and queued two deep, so the request port keeps
// taking requests while the back end works and a result waits, until the queue
// is full. The back end handles one request at a time. An allocate searches the
// free map eight pages a cycle, stopping early at a run; if one is found, it
// updates each 32-bit map word of the run, then loads the result register. A
// release updates each map word in its range, then loads the result register;
// a rejected request goes straight to the result register. The free map holds
// no free page after reset and needs no clearing pass.
module contiguous_page_allocator
    import cpa_pkg::*;
#(
    parameter int NUM_PAGES = 256
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [OPCODE_W-1:0]   s_opcode,
    input  logic [COUNT_W-1:0]    s_page_count,
    input  logic [START_W-1:0]    s_start_page,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [STATUS_W-1:0]   m_status,
    output logic [PAGE_NUM_W-1:0] m_page_number,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int CAP = (NUM_PAGES < MAP_CAP) ? NUM_PAGES : MAP_CAP;
    localparam logic [POS_W-1:0] CAP_POS = POS_W'(CAP);

    logic [BASE_W-1:0]  base_page_reg;
    logic [COUNT_W-1:0] pages_in_use_reg;
    logic [COUNT_W-1:0] limit;

    logic               f_valid, f_ready;
    cmd_t               f_cmd;
    logic               q_valid, q_ready;
    logic [$bits(cmd_t)-1:0] q_data;
    cmd_t               q_cmd;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_page_reg    <= '0;
            pages_in_use_reg <= COUNT_W'(256);
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_BASE_PAGE:    base_page_reg    <= cfg_data[BASE_W-1:0];
                REG_PAGES_IN_USE: pages_in_use_reg <= cfg_data[COUNT_W-1:0];
                default:          ;
            endcase
        end
    end

    assign limit = (POS_W'(pages_in_use_reg) < CAP_POS) ? pages_in_use_reg
                                                         : CAP_POS[COUNT_W-1:0];

    cpa_front u_front (
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_opcode     (s_opcode),
        .s_page_count (s_page_count),
        .s_start_page (s_start_page),
        .limit        (limit),
        .q_valid      (f_valid),
        .q_ready      (f_ready),
        .q_cmd        (f_cmd)
    );

    cpa_queue #(
        .WIDTH ($bits(cmd_t)),
        .DEPTH (2)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .in_data   (f_cmd),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_data  (q_data)
    );

    assign q_cmd = q_data;

    cpa_back #(
        .NUM_PAGES (NUM_PAGES)
    ) u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .q_valid       (q_valid),
        .q_ready       (q_ready),
        .q_cmd         (q_cmd),
        .limit         (limit),
        .base_page     (base_page_reg),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_status      (m_status),
        .m_page_number (m_page_number)
    );

endmodule
